// File: hdl/rdu_pkg.sv
// Package for the refraction direction unit: constants, word types and helpers.
`default_nettype none

package rdu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 8;
  localparam int FIELD_W   = 24;
  localparam int RATIO_W   = 18;

  // Squared components and their sum.
  localparam int SQ_W  = 2 * FIELD_W - 1;
  localparam int SUM_W = SQ_W + 1;
  // Length stage: root of the sum scaled by 2^14.
  localparam int LEN_PAD = 14;
  localparam int RAD1_W  = SUM_W + LEN_PAD;
  localparam int LEN_W   = RAD1_W / 2;
  // Normalizing divide: |d| * 2^(F+7) over the length. The magnitude of the
  // most negative component needs all FIELD_W bits.
  localparam int NORM_SHIFT = FRAC_BITS + 7;
  localparam int DVD_W      = FIELD_W + NORM_SHIFT;
  localparam int QUO_W      = FRAC_BITS + 1;
  // Unit vector components and the cosine.
  localparam int UNIT_W = FRAC_BITS + 2;
  // eta*c after the fraction shift, and the radicand of the second root.
  localparam int ECS_W   = RATIO_W + 1 + UNIT_W - FRAC_BITS;
  localparam int RAD2_W  = 2 * FRAC_BITS + 2;
  localparam int ROOT2_W = RAD2_W / 2;
  localparam int X_W     = ECS_W + 1;
  // Final sum before saturation.
  localparam int A_W = RATIO_W + 1 + UNIT_W;
  localparam int B_W = X_W + FIELD_W;
  localparam int R_W = B_W - FRAC_BITS + 1;

  typedef logic signed [FIELD_W-1:0] fix_t;
  typedef logic [RATIO_W-1:0]        ratio_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;
  typedef logic signed [ECS_W-1:0]   ecs_t;

  typedef struct packed {
    fix_t   dir_x;
    fix_t   dir_y;
    fix_t   dir_z;
    fix_t   norm_x;
    fix_t   norm_y;
    fix_t   norm_z;
    ratio_t index_ratio;
  } rdu_in_t;

  typedef struct packed {
    fix_t out_x;
    fix_t out_y;
    fix_t out_z;
    logic total_internal;
    logic zero_length;
  } rdu_out_t;

  typedef struct packed {
    rdu_in_t w;
    logic    zero;
  } front_sb_t;

  typedef struct packed {
    fix_t       norm_x;
    fix_t       norm_y;
    fix_t       norm_z;
    ratio_t     eta;
    logic       zero;
    logic [2:0] neg;
  } div_sb_t;

  typedef struct packed {
    unit_t  u_x;
    unit_t  u_y;
    unit_t  u_z;
    fix_t   norm_x;
    fix_t   norm_y;
    fix_t   norm_z;
    ratio_t eta;
    logic   zero;
  } cos_in_t;

  typedef struct packed {
    ecs_t   ecs;
    unit_t  u_x;
    unit_t  u_y;
    unit_t  u_z;
    fix_t   norm_x;
    fix_t   norm_y;
    fix_t   norm_z;
    ratio_t eta;
    logic   tir;
    logic   zero;
  } back_sb_t;

  localparam longint SAT_HI = (64'sd1 <<< (INT_BITS + FRAC_BITS - 1)) - 64'sd1;

  // Saturate a wide signed sum to the output field.
  function automatic fix_t sat_fix(input logic signed [R_W-1:0] v);
    logic signed [R_W-1:0] hi;
    logic signed [R_W-1:0] lo;
    hi = R_W'(SAT_HI);
    lo = -hi - R_W'(1);
    if (v > hi) begin
      return FIELD_W'(hi);
    end else if (v < lo) begin
      return FIELD_W'(lo);
    end
    return FIELD_W'(v);
  endfunction

endpackage

`default_nettype wire

// File: hdl/rdu_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband.
`default_nettype none

module rdu_isqrt #(
  parameter int IN_W = 62,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_rad,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [IN_W/2-1:0] out_root,
  output logic [SB_W-1:0]   out_sb
);

  localparam int RES_W = IN_W / 2;

  logic            vld_r  [RES_W];
  logic [IN_W-1:0] rem_r  [RES_W-1];
  logic [IN_W-1:0] root_r [RES_W];
  logic [SB_W-1:0] sb_r   [RES_W];

  for (genvar s = 0; s < RES_W; s++) begin : g_stage
    localparam logic [IN_W-1:0] BIT = {{(IN_W-1){1'b0}}, 1'b1} << (2 * (RES_W - 1 - s));
    logic            vld_in;
    logic [IN_W-1:0] rem_in;
    logic [IN_W-1:0] root_in;
    logic [IN_W-1:0] trial;
    logic [IN_W-1:0] rem_nxt;
    logic [IN_W-1:0] root_nxt;
    logic [SB_W-1:0] sb_in;

    if (s == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_rad;
      assign root_in = '0;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign sb_in   = sb_r[s-1];
    end

    always_comb begin
      trial = root_in + BIT;
      if (rem_in >= trial) begin
        rem_nxt  = rem_in - trial;
        root_nxt = (root_in >> 1) + BIT;
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[s] <= root_nxt;
        sb_r[s]   <= sb_in;
      end
    end

    if (s < RES_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
        end
      end
    end
  end

  assign out_valid = vld_r[RES_W-1];
  assign out_root  = root_r[RES_W-1][RES_W-1:0];
  assign out_sb    = sb_r[RES_W-1];

endmodule

`default_nettype wire

// File: hdl/rdu_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
`default_nettype none

module rdu_div #(
  parameter int DVD_W = 47,
  parameter int DVS_W = 31,
  parameter int Q_W   = 17,
  parameter int SB_W  = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2:0][DVD_W-1:0] in_dvd,
  input  logic [DVS_W-1:0]      in_dvs,
  input  logic [SB_W-1:0]       in_sb,
  output logic                  out_valid,
  output logic [2:0][Q_W-1:0]   out_quo,
  output logic [SB_W-1:0]       out_sb
);

  logic                  vld_r [Q_W];
  logic [2:0][DVD_W-1:0] rem_r [Q_W-1];
  logic [DVS_W-1:0]      dvs_r [Q_W-1];
  logic [2:0][Q_W-1:0]   quo_r [Q_W];
  logic [SB_W-1:0]       sb_r  [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic                  vld_in;
    logic [2:0][DVD_W-1:0] rem_in;
    logic [2:0][DVD_W-1:0] rem_nxt;
    logic [DVS_W-1:0]      dvs_in;
    logic [2:0][Q_W-1:0]   quo_in;
    logic [2:0][Q_W-1:0]   quo_nxt;
    logic [SB_W-1:0]       sb_in;
    logic [DVD_W-1:0]      sub;

    if (s == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = in_dvd;
      assign dvs_in = in_dvs;
      assign quo_in = '0;
      assign sb_in  = in_sb;
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign rem_in = rem_r[s-1];
      assign dvs_in = dvs_r[s-1];
      assign quo_in = quo_r[s-1];
      assign sb_in  = sb_r[s-1];
    end

    always_comb begin
      sub = DVD_W'(dvs_in) << (Q_W - 1 - s);
      for (int l = 0; l < 3; l++) begin
        quo_nxt[l] = quo_in[l];
        if (rem_in[l] >= sub) begin
          rem_nxt[l] = rem_in[l] - sub;
          quo_nxt[l][Q_W-1-s] = 1'b1;
        end else begin
          rem_nxt[l] = rem_in[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s] <= quo_nxt;
        sb_r[s]  <= sb_in;
      end
    end

    if (s < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
          dvs_r[s] <= dvs_in;
        end
      end
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign out_quo   = quo_r[Q_W-1];
  assign out_sb    = sb_r[Q_W-1];

endmodule

`default_nettype wire

// File: hdl/rdu_cos.sv
// Cosine and radicand stages: dot product, clamp, squares and the Snell radicand.
`default_nettype none

module rdu_cos
  import rdu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  cos_in_t           in_pay,
  output logic              out_valid,
  output logic [RAD2_W-1:0] out_rad,
  output back_sb_t          out_sb
);

  localparam int PROD_W = UNIT_W + FIELD_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int NDOT_W = DOT_W + 1;
  localparam int CFL_W  = NDOT_W - FRAC_BITS;
  localparam int CSQ_W  = 2 * FRAC_BITS + 1;
  localparam int ESQ_W  = 2 * RATIO_W;
  localparam int EC_W   = RATIO_W + 1 + UNIT_W;
  localparam int EQ_W   = ESQ_W - FRAC_BITS;
  localparam int TQ_W   = CSQ_W - FRAC_BITS;
  localparam int P_W    = EQ_W + TQ_W;
  localparam int ONE_I  = 1 << FRAC_BITS;
  localparam logic [CSQ_W-1:0] ONE2 = {1'b1, {(2 * FRAC_BITS){1'b0}}};
  localparam logic signed [P_W:0] K_ONE =
    {{(P_W - 2 * FRAC_BITS){1'b0}}, 1'b1, {(2 * FRAC_BITS){1'b0}}};

  // Stage 1: the three products of the dot product.
  logic                     c1_v_r;
  cos_in_t                  c1_p_r;
  logic signed [PROD_W-1:0] c1_prod_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
    end else if (en) begin
      c1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_p_r       <= in_pay;
      c1_prod_r[0] <= $signed(in_pay.u_x) * $signed(in_pay.norm_x);
      c1_prod_r[1] <= $signed(in_pay.u_y) * $signed(in_pay.norm_y);
      c1_prod_r[2] <= $signed(in_pay.u_z) * $signed(in_pay.norm_z);
    end
  end

  // Stage 2: sum, negate, floor to the fraction and clamp to [-1, 1].
  logic                    c2_v_r;
  cos_in_t                 c2_p_r;
  unit_t                   c2_c_r;
  logic signed [DOT_W-1:0]  dot;
  logic signed [NDOT_W-1:0] ndot;
  logic signed [CFL_W-1:0]  cfl;
  unit_t                    c_nxt;

  always_comb begin
    dot  = DOT_W'(c1_prod_r[0]) + DOT_W'(c1_prod_r[1]) + DOT_W'(c1_prod_r[2]);
    ndot = -NDOT_W'(dot);
    cfl  = CFL_W'(ndot >>> FRAC_BITS);
    if (cfl > ONE_I) begin
      c_nxt = UNIT_W'(ONE_I);
    end else if (cfl < -ONE_I) begin
      c_nxt = UNIT_W'(-ONE_I);
    end else begin
      c_nxt = UNIT_W'(cfl);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_v_r <= 1'b0;
    end else if (en) begin
      c2_v_r <= c1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_p_r <= c1_p_r;
      c2_c_r <= c_nxt;
    end
  end

  // Stage 3: c squared, eta squared and eta times c.
  logic                      c3_v_r;
  cos_in_t                   c3_p_r;
  logic [CSQ_W-1:0]          c3_csq_r;
  logic [ESQ_W-1:0]          c3_esq_r;
  logic signed [EC_W-1:0]    c3_ec_r;
  logic signed [2*UNIT_W-1:0] csq_full;

  assign csq_full = c2_c_r * c2_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_v_r <= 1'b0;
    end else if (en) begin
      c3_v_r <= c2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_p_r   <= c2_p_r;
      c3_csq_r <= csq_full[CSQ_W-1:0];
      c3_esq_r <= c2_p_r.eta * c2_p_r.eta;
      c3_ec_r  <= $signed({1'b0, c2_p_r.eta}) * c2_c_r;
    end
  end

  // Stage 4: p = floor(eta^2) * floor(1 - c^2), both at the fraction.
  logic             c4_v_r;
  cos_in_t          c4_p_r;
  logic [P_W-1:0]   c4_p_prod_r;
  ecs_t             c4_ecs_r;
  logic [CSQ_W-1:0] tval;

  assign tval = ONE2 - c3_csq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_v_r <= 1'b0;
    end else if (en) begin
      c4_v_r <= c3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4_p_r      <= c3_p_r;
      c4_p_prod_r <= c3_esq_r[ESQ_W-1:FRAC_BITS] * tval[CSQ_W-1:FRAC_BITS];
      c4_ecs_r    <= ECS_W'(c3_ec_r >>> FRAC_BITS);
    end
  end

  // Stage 5: k = 1 - p; a negative k means total internal reflection.
  logic               c5_v_r;
  logic [RAD2_W-1:0]  c5_rad_r;
  back_sb_t           c5_sb_r;
  logic signed [P_W:0] kval;
  logic               tir;

  assign kval = K_ONE - $signed({1'b0, c4_p_prod_r});
  assign tir  = kval[P_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c5_v_r <= 1'b0;
    end else if (en) begin
      c5_v_r <= c4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c5_rad_r       <= tir ? '0 : kval[RAD2_W-1:0];
      c5_sb_r.ecs    <= c4_ecs_r;
      c5_sb_r.u_x    <= c4_p_r.u_x;
      c5_sb_r.u_y    <= c4_p_r.u_y;
      c5_sb_r.u_z    <= c4_p_r.u_z;
      c5_sb_r.norm_x <= c4_p_r.norm_x;
      c5_sb_r.norm_y <= c4_p_r.norm_y;
      c5_sb_r.norm_z <= c4_p_r.norm_z;
      c5_sb_r.eta    <= c4_p_r.eta;
      c5_sb_r.tir    <= tir;
      c5_sb_r.zero   <= c4_p_r.zero;
    end
  end

  assign out_valid = c5_v_r;
  assign out_rad   = c5_rad_r;
  assign out_sb    = c5_sb_r;

endmodule

`default_nettype wire

// File: hdl/refraction_direction_unit.sv
// Top level of the refraction direction unit: front squares, units, final combine, output.
//
// Usage: one word on in_word per accepted cycle carries the incident direction,
// the unit surface normal and the index ratio eta, all fixed point with 16
// fraction bits. For each input word the block returns exactly one word on
// out_word: the refracted direction eta*u + (eta*c - sqrt(k))*n, saturated,
// where u is the normalized direction and c = -(u . n) clamped to [-1, 1].
// A zero-length direction sets zero_length, a negative radicand sets
// total_internal; either flag forces the vector to zero.
// A word is accepted on a rising edge with valid high and stall low.
// From acceptance to out_valid a word passes 2 front stages, a 31-stage
// length root, a 17-stage normalizing divider (one quotient bit per stage),
// 5 cosine stages, a 17-stage radicand root, 3 combine stages and the
// output register. Throughput is one word per cycle while in_stall is low.
// When the receiver stalls, the pipeline keeps moving until one finished
// word waits in a skid register behind the output register; only then does
// in_stall rise, and the whole pipeline holds without losing a word.
// Synchronous active-low reset clears all valid bits; the block holds no
// other state.
`default_nettype none

module refraction_direction_unit
  import rdu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rdu_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output rdu_out_t out_word
);

  // The pipeline advances whenever the skid register is free.
  logic en;
  logic skid_v_r;
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // Front stage 1: square each direction component.
  logic           f1_v_r;
  rdu_in_t        f1_w_r;
  logic [SQ_W-1:0] f1_sq_r [3];
  logic signed [2*FIELD_W-1:0] sq_full [3];

  always_comb begin
    sq_full[0] = $signed(in_word.dir_x) * $signed(in_word.dir_x);
    sq_full[1] = $signed(in_word.dir_y) * $signed(in_word.dir_y);
    sq_full[2] = $signed(in_word.dir_z) * $signed(in_word.dir_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_w_r <= in_word;
      for (int i = 0; i < 3; i++) begin
        f1_sq_r[i] <= sq_full[i][SQ_W-1:0];
      end
    end
  end

  // Front stage 2: sum of squares and the zero-length test.
  logic             f2_v_r;
  logic [SUM_W-1:0] f2_sum_r;
  front_sb_t        f2_sb_r;
  logic [SUM_W-1:0] sum;

  assign sum = SUM_W'(f1_sq_r[0]) + SUM_W'(f1_sq_r[1]) + SUM_W'(f1_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (en) begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_sum_r     <= sum;
      f2_sb_r.w    <= f1_w_r;
      f2_sb_r.zero <= (sum == '0);
    end
  end

  // Length: floor(sqrt(S * 2^14)).
  logic             len_v;
  logic [LEN_W-1:0] len;
  front_sb_t        len_sb;

  rdu_isqrt #(
    .IN_W (RAD1_W),
    .SB_W ($bits(front_sb_t))
  ) u_len_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f2_v_r),
    .in_rad    ({f2_sum_r, {LEN_PAD{1'b0}}}),
    .in_sb     (f2_sb_r),
    .out_valid (len_v),
    .out_root  (len),
    .out_sb    (len_sb)
  );

  // Normalize: divide the magnitudes, restore signs afterwards.
  logic [FIELD_W:0]      mag  [3];
  fix_t                  dcmp [3];
  logic [2:0][DVD_W-1:0] dvd;
  div_sb_t               div_sb_in;

  always_comb begin
    dcmp[0] = len_sb.w.dir_x;
    dcmp[1] = len_sb.w.dir_y;
    dcmp[2] = len_sb.w.dir_z;
    for (int i = 0; i < 3; i++) begin
      mag[i] = dcmp[i][FIELD_W-1] ? -{dcmp[i][FIELD_W-1], dcmp[i]}
                                  : {dcmp[i][FIELD_W-1], dcmp[i]};
      dvd[i] = {mag[i][FIELD_W-1:0], {NORM_SHIFT{1'b0}}};
      div_sb_in.neg[i] = dcmp[i][FIELD_W-1];
    end
    div_sb_in.norm_x = len_sb.w.norm_x;
    div_sb_in.norm_y = len_sb.w.norm_y;
    div_sb_in.norm_z = len_sb.w.norm_z;
    div_sb_in.eta    = len_sb.w.index_ratio;
    div_sb_in.zero   = len_sb.zero;
  end

  logic                div_v;
  logic [2:0][QUO_W-1:0] quo;
  div_sb_t             div_sb;

  rdu_div #(
    .DVD_W (DVD_W),
    .DVS_W (LEN_W),
    .Q_W   (QUO_W),
    .SB_W  ($bits(div_sb_t))
  ) u_norm_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (len_v),
    .in_dvd    (dvd),
    .in_dvs    (len),
    .in_sb     (div_sb_in),
    .out_valid (div_v),
    .out_quo   (quo),
    .out_sb    (div_sb)
  );

  // Signed unit vector into the cosine stages.
  cos_in_t cos_in;
  unit_t   ucmp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ucmp[i] = div_sb.neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
    end
    cos_in.u_x    = ucmp[0];
    cos_in.u_y    = ucmp[1];
    cos_in.u_z    = ucmp[2];
    cos_in.norm_x = div_sb.norm_x;
    cos_in.norm_y = div_sb.norm_y;
    cos_in.norm_z = div_sb.norm_z;
    cos_in.eta    = div_sb.eta;
    cos_in.zero   = div_sb.zero;
  end

  logic              cos_v;
  logic [RAD2_W-1:0] rad2;
  back_sb_t          cos_sb;

  rdu_cos u_cos (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_v),
    .in_pay    (cos_in),
    .out_valid (cos_v),
    .out_rad   (rad2),
    .out_sb    (cos_sb)
  );

  // Root of the radicand.
  logic               rt_v;
  logic [ROOT2_W-1:0] root2;
  back_sb_t           rt_sb;

  rdu_isqrt #(
    .IN_W (RAD2_W),
    .SB_W ($bits(back_sb_t))
  ) u_rad_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cos_v),
    .in_rad    (rad2),
    .in_sb     (cos_sb),
    .out_valid (rt_v),
    .out_root  (root2),
    .out_sb    (rt_sb)
  );

  // Combine stage 1: x = floor(eta*c) - sqrt(k).
  logic                  b1_v_r;
  logic signed [X_W-1:0] b1_x_r;
  back_sb_t              b1_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r <= rt_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_x_r  <= X_W'(rt_sb.ecs) - X_W'($signed({1'b0, root2}));
      b1_sb_r <= rt_sb;
    end
  end

  // Combine stage 2: eta*u_i and x*n_i.
  logic                  b2_v_r;
  logic signed [A_W-1:0] b2_a_r [3];
  logic signed [B_W-1:0] b2_b_r [3];
  logic                  b2_tir_r;
  logic                  b2_zero_r;
  logic signed [RATIO_W:0] eta_s;

  assign eta_s = $signed({1'b0, b1_sb_r.eta});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_v_r <= 1'b0;
    end else if (en) begin
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_a_r[0] <= eta_s * $signed(b1_sb_r.u_x);
      b2_a_r[1] <= eta_s * $signed(b1_sb_r.u_y);
      b2_a_r[2] <= eta_s * $signed(b1_sb_r.u_z);
      b2_b_r[0] <= b1_x_r * $signed(b1_sb_r.norm_x);
      b2_b_r[1] <= b1_x_r * $signed(b1_sb_r.norm_y);
      b2_b_r[2] <= b1_x_r * $signed(b1_sb_r.norm_z);
      b2_tir_r  <= b1_sb_r.tir;
      b2_zero_r <= b1_sb_r.zero;
    end
  end

  // Combine stage 3: floor both terms, add, saturate, apply the flags.
  logic                  b3_v_r;
  rdu_out_t              b3_r;
  logic signed [R_W-1:0] rsum [3];
  fix_t                  rsat [3];
  logic                  flagged;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = R_W'(b2_a_r[i] >>> FRAC_BITS) + R_W'(b2_b_r[i] >>> FRAC_BITS);
      rsat[i] = sat_fix(rsum[i]);
    end
    flagged = b2_tir_r || b2_zero_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_v_r <= 1'b0;
    end else if (en) begin
      b3_v_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_r.out_x          <= flagged ? '0 : rsat[0];
      b3_r.out_y          <= flagged ? '0 : rsat[1];
      b3_r.out_z          <= flagged ? '0 : rsat[2];
      b3_r.total_internal <= b2_tir_r && !b2_zero_r;
      b3_r.zero_length    <= b2_zero_r;
    end
  end

  // Output register with a one-word skid behind it.
  logic     out_v_r;
  rdu_out_t out_r;
  rdu_out_t skid_r;
  logic     out_free;

  assign out_free = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= b3_v_r;
      end
    end else if (b3_v_r && !skid_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_v_r ? skid_r : b3_r;
    end
    if (!out_free && !skid_v_r) begin
      skid_r <= b3_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

  // The skid register only holds a word while the output register is full.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word present while output register is empty");

  // The skid register fills only after the receiver stalled a valid word.
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && out_stall))
    else $error("skid filled without a stalled output word");

  // The two flags never rise together.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_r.total_internal && out_r.zero_length))
    else $error("both result flags set");

  // A flagged word carries a zero vector.
  a_flagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_r.total_internal || out_r.zero_length) |->
      (out_r.out_x == '0) && (out_r.out_y == '0) && (out_r.out_z == '0))
    else $error("flagged word with a nonzero vector");

endmodule

`default_nettype wire
